// ----- rtl/core/lobm_pkg.sv -----
// Package of the limit order book matcher: table size, request and status codes,
// and the packed record of one resting order. No dependencies.
package lobm_pkg;

    localparam int MAX_ORDERS = 32;
    localparam int IDX_W      = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_CANCEL = 2'd1;
    localparam logic [1:0] ACT_REDUCE = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic       SIDE_BUY  = 1'b0;
    localparam logic       SIDE_SELL = 1'b1;

    localparam logic [1:0] KIND_LIMIT  = 2'd0;
    localparam logic [1:0] KIND_MARKET = 2'd1;
    localparam logic [1:0] KIND_IOC    = 2'd2;
    localparam logic [1:0] KIND_BAD    = 2'd3;

    localparam logic [1:0] ST_NEW       = 2'd0;
    localparam logic [1:0] ST_PARTIAL   = 2'd1;
    localparam logic [1:0] ST_FILLED    = 2'd2;
    localparam logic [1:0] ST_CANCELLED = 2'd3;

    localparam logic       RES_TRADE = 1'b0;
    localparam logic       RES_DONE  = 1'b1;

    typedef struct packed {
        logic [31:0] id;
        logic        side;
        logic [31:0] price;
        logic [31:0] size;
        logic [31:0] filled;
        logic [31:0] arrival;
    } t_slot;

endpackage

// ----- rtl/core/limit_order_book_matcher.sv -----
// Top level of the limit order book matcher: request sequencer around the slot memory.
// Depends on lobm_pkg and lobm_ram.
//
// Resting orders live in one slot memory of MAX_ORDERS entries, read one entry a cycle;
// valid bits sit in flip-flops and are clear after reset, so no clearing pass is needed.
// Every table search is one sweep of all MAX_ORDERS entries through the memory read port.
// A cancel or reduce takes two sweeps; an add takes one sweep per fill, one more to find
// the end of matching unless the order is fully filled, and a final sweep for the best
// prices, with a trade item issued after each fill and the completion item at the end.
// A failed add or an unused action takes one sweep.
// The next request is taken while the completion item still waits at the output.
module limit_order_book_matcher (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_action,
    input  logic                         i_side,
    input  logic [1:0]                   i_order_kind,
    input  logic signed [31:0]           i_limit_price,
    input  logic [31:0]                  i_quantity,
    input  logic [63:0]                  i_time_stamp,
    input  logic [31:0]                  i_target_id,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_result_kind,
    output logic [31:0]                  o_aggressor_id,
    output logic [31:0]                  o_passive_id,
    output logic signed [31:0]           o_trade_price,
    output logic [31:0]                  o_trade_qty,
    output logic [63:0]                  o_trade_time,
    output logic [31:0]                  o_order_ident,
    output logic                         o_ok,
    output logic [1:0]                   o_order_status,
    output logic signed [31:0]           o_best_bid,
    output logic signed [31:0]           o_best_ask,
    output logic                         o_last
);

    import lobm_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_MATCH, S_TRADE, S_APPLY, S_DONE} t_state;
    typedef enum logic [1:0] {M_MATCH, M_ID, M_FINAL} t_mode;

    t_state                r_state;
    t_mode                 r_mode;
    logic [MAX_ORDERS-1:0] r_valid;
    logic [31:0]           r_next_id;
    logic [31:0]           r_arr_cnt;

    logic [1:0]  r_action;
    logic        r_side;
    logic [1:0]  r_kind;
    logic [31:0] r_lim;
    logic [31:0] r_qty;
    logic [63:0] r_tm;
    logic [31:0] r_target;
    logic [31:0] r_aid;
    logic [31:0] r_rem;
    logic [31:0] r_fill;
    logic [31:0] r_ident;
    logic        r_ok;
    logic [1:0]  r_status;

    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_on;
    logic             r_chk;
    logic [IDX_W-1:0] r_chk_idx;

    logic             r_opp_found;
    logic [IDX_W-1:0] r_opp_idx;
    t_slot            r_opp;
    logic             r_bid_found;
    logic [31:0]      r_bid;
    logic             r_ask_found;
    logic [31:0]      r_ask;
    logic             r_id_found;
    logic [IDX_W-1:0] r_id_idx;
    t_slot            r_id_rec;

    logic        r_out_valid;
    logic        r_o_kind;
    logic [31:0] r_o_aggr;
    logic [31:0] r_o_pas;
    logic [31:0] r_o_price;
    logic [31:0] r_o_qty;
    logic [63:0] r_o_time;
    logic [31:0] r_o_ident;
    logic        r_o_ok;
    logic [1:0]  r_o_status;
    logic [31:0] r_o_bid;
    logic [31:0] r_o_ask;
    logic        r_o_last;

    t_slot            s_rec;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_slot            wr_data;
    logic             rd_en;

    logic             out_free;
    logic             in_acc;
    logic [31:0]      n_next_id;
    logic [IDX_W-1:0] free_idx;
    logic             cand_valid;
    logic [31:0]      age_c;
    logic [31:0]      age_b;
    logic             opp_better;
    logic             bid_better;
    logic             ask_better;
    logic             id_hit;
    logic             scan_end;
    logic [31:0]      avail;
    logic [31:0]      fill;
    logic [31:0]      new_filled;
    logic             no_cross;
    logic             red_ok;

    lobm_ram #(
        .WIDTH($bits(t_slot)),
        .DEPTH(MAX_ORDERS)
    ) u_slots (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_rd_idx),
        .o_rd_data(s_rec)
    );

    function automatic logic [IDX_W-1:0] first_free(input logic [MAX_ORDERS-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = MAX_ORDERS - 1; i >= 0; i--) begin
            if (!v[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_acc    = (r_state == S_IDLE) && i_in_valid;
    assign n_next_id = (r_next_id == 32'hFFFF_FFFF) ? 32'd1 : r_next_id + 32'd1;
    assign free_idx  = first_free(r_valid);

    assign cand_valid = r_chk && r_valid[r_chk_idx];
    assign age_c      = r_arr_cnt - s_rec.arrival;
    assign age_b      = r_arr_cnt - r_opp.arrival;
    assign scan_end   = r_chk && (r_chk_idx == IDX_W'(MAX_ORDERS - 1));

    always_comb begin
        opp_better = 1'b0;
        if (cand_valid && s_rec.side != r_side) begin
            if (!r_opp_found) begin
                opp_better = 1'b1;
            end else if (r_side == SIDE_BUY ? $signed(s_rec.price) < $signed(r_opp.price)
                                            : $signed(s_rec.price) > $signed(r_opp.price)) begin
                opp_better = 1'b1;
            end else if (s_rec.price == r_opp.price && age_c > age_b) begin
                opp_better = 1'b1;
            end
        end
    end

    assign bid_better = cand_valid && s_rec.side == SIDE_BUY &&
                        (!r_bid_found || $signed(s_rec.price) > $signed(r_bid));
    assign ask_better = cand_valid && s_rec.side == SIDE_SELL &&
                        (!r_ask_found || $signed(s_rec.price) < $signed(r_ask));
    assign id_hit     = cand_valid && !r_id_found && s_rec.id == r_target;

    assign avail      = (r_opp.size > r_opp.filled) ? r_opp.size - r_opp.filled : 32'd0;
    assign fill       = (r_rem < avail) ? r_rem : avail;
    assign new_filled = r_opp.filled + fill;
    assign no_cross   = (r_kind != KIND_MARKET) &&
                        (r_side == SIDE_BUY ? $signed(r_lim) < $signed(r_opp.price)
                                            : $signed(r_lim) > $signed(r_opp.price));
    assign red_ok     = r_qty < r_id_rec.size && r_qty > r_id_rec.filled;

    always_comb begin
        rd_en   = (r_state == S_SCAN) && r_rd_on;
        wr_en   = 1'b0;
        wr_addr = r_opp_idx;
        wr_data = r_opp;
        case (r_state)
            S_MATCH: begin
                if (!r_opp_found || no_cross) begin
                    wr_en           = (r_kind == KIND_LIMIT);
                    wr_addr         = free_idx;
                    wr_data.id      = r_aid;
                    wr_data.side    = r_side;
                    wr_data.price   = r_lim;
                    wr_data.size    = r_qty;
                    wr_data.filled  = r_qty - r_rem;
                    wr_data.arrival = r_arr_cnt;
                end else begin
                    wr_en          = 1'b1;
                    wr_data.filled = new_filled;
                end
            end
            S_APPLY: begin
                wr_en        = r_id_found && r_action == ACT_REDUCE && red_ok;
                wr_addr      = r_id_idx;
                wr_data      = r_id_rec;
                wr_data.size = r_qty;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= M_FINAL;
            r_valid     <= '0;
            r_next_id   <= 32'd1;
            r_arr_cnt   <= 32'd0;
            r_out_valid <= 1'b0;
            r_rd_on     <= 1'b0;
            r_chk       <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_TRADE && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_action    <= i_action;
                        r_side      <= i_side;
                        r_kind      <= i_order_kind;
                        r_lim       <= i_limit_price;
                        r_qty       <= i_quantity;
                        r_tm        <= i_time_stamp;
                        r_target    <= i_target_id;
                        r_rem       <= i_quantity;
                        r_state     <= S_SCAN;
                        r_rd_idx    <= '0;
                        r_rd_on     <= 1'b1;
                        r_chk       <= 1'b0;
                        r_opp_found <= 1'b0;
                        r_bid_found <= 1'b0;
                        r_ask_found <= 1'b0;
                        r_id_found  <= 1'b0;
                        case (i_action)
                            ACT_ADD: begin
                                if (i_order_kind != KIND_BAD && !(&r_valid)) begin
                                    r_aid     <= r_next_id;
                                    r_ident   <= r_next_id;
                                    r_ok      <= 1'b1;
                                    r_next_id <= n_next_id;
                                    if (i_quantity == 32'd0) begin
                                        r_status <= ST_FILLED;
                                        r_mode   <= M_FINAL;
                                    end else begin
                                        r_status <= ST_NEW;
                                        r_mode   <= M_MATCH;
                                    end
                                end else begin
                                    r_ident  <= 32'd0;
                                    r_ok     <= 1'b0;
                                    r_status <= ST_NEW;
                                    r_mode   <= M_FINAL;
                                end
                            end
                            ACT_CANCEL, ACT_REDUCE: begin
                                r_ident  <= i_target_id;
                                r_ok     <= 1'b0;
                                r_status <= ST_NEW;
                                r_mode   <= M_ID;
                            end
                            default: begin
                                r_ident  <= i_target_id;
                                r_ok     <= 1'b0;
                                r_status <= ST_NEW;
                                r_mode   <= M_FINAL;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_rd_on) begin
                        if (r_rd_idx == IDX_W'(MAX_ORDERS - 1)) begin
                            r_rd_on <= 1'b0;
                        end else begin
                            r_rd_idx <= r_rd_idx + 1'b1;
                        end
                    end
                    r_chk     <= r_rd_on;
                    r_chk_idx <= r_rd_idx;
                    if (opp_better) begin
                        r_opp_found <= 1'b1;
                        r_opp_idx   <= r_chk_idx;
                        r_opp       <= s_rec;
                    end
                    if (bid_better) begin
                        r_bid_found <= 1'b1;
                        r_bid       <= s_rec.price;
                    end
                    if (ask_better) begin
                        r_ask_found <= 1'b1;
                        r_ask       <= s_rec.price;
                    end
                    if (id_hit) begin
                        r_id_found <= 1'b1;
                        r_id_idx   <= r_chk_idx;
                        r_id_rec   <= s_rec;
                    end
                    if (scan_end) begin
                        case (r_mode)
                            M_MATCH: r_state <= S_MATCH;
                            M_ID:    r_state <= S_APPLY;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_MATCH: begin
                    r_rd_idx    <= '0;
                    r_rd_on     <= 1'b1;
                    r_opp_found <= 1'b0;
                    r_bid_found <= 1'b0;
                    r_ask_found <= 1'b0;
                    r_id_found  <= 1'b0;
                    if (!r_opp_found || no_cross) begin
                        if (r_kind == KIND_LIMIT) begin
                            r_valid[free_idx] <= 1'b1;
                            r_arr_cnt         <= r_arr_cnt + 32'd1;
                            r_status          <= (r_rem != r_qty) ? ST_PARTIAL : ST_NEW;
                        end else begin
                            r_status <= ST_CANCELLED;
                        end
                        r_mode  <= M_FINAL;
                        r_state <= S_SCAN;
                    end else begin
                        r_fill <= fill;
                        r_rem  <= r_rem - fill;
                        if (new_filled >= r_opp.size) begin
                            r_valid[r_opp_idx] <= 1'b0;
                        end
                        if (fill != 32'd0) begin
                            r_state <= S_TRADE;
                        end else begin
                            r_state <= S_SCAN;
                            if (r_rem == 32'd0) begin
                                r_status <= ST_FILLED;
                                r_mode   <= M_FINAL;
                            end else begin
                                r_mode <= M_MATCH;
                            end
                        end
                    end
                end
                S_TRADE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_kind    <= RES_TRADE;
                        r_o_aggr    <= r_aid;
                        r_o_pas     <= r_opp.id;
                        r_o_price   <= r_opp.price;
                        r_o_qty     <= r_fill;
                        r_o_time    <= r_tm;
                        r_o_ident   <= 32'd0;
                        r_o_ok      <= 1'b0;
                        r_o_status  <= ST_NEW;
                        r_o_bid     <= 32'd0;
                        r_o_ask     <= 32'd0;
                        r_o_last    <= 1'b0;
                        r_state     <= S_SCAN;
                        if (r_rem == 32'd0) begin
                            r_status <= ST_FILLED;
                            r_mode   <= M_FINAL;
                        end else begin
                            r_mode <= M_MATCH;
                        end
                    end
                end
                S_APPLY: begin
                    r_rd_idx    <= '0;
                    r_rd_on     <= 1'b1;
                    r_opp_found <= 1'b0;
                    r_bid_found <= 1'b0;
                    r_ask_found <= 1'b0;
                    r_id_found  <= 1'b0;
                    r_mode      <= M_FINAL;
                    r_state     <= S_SCAN;
                    if (r_id_found) begin
                        if (r_action == ACT_CANCEL) begin
                            r_valid[r_id_idx] <= 1'b0;
                            r_ok              <= 1'b1;
                            r_status          <= ST_CANCELLED;
                        end else if (red_ok) begin
                            r_ok     <= 1'b1;
                            r_status <= (r_id_rec.filled != 32'd0) ? ST_PARTIAL : ST_NEW;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_kind    <= RES_DONE;
                        r_o_aggr    <= 32'd0;
                        r_o_pas     <= 32'd0;
                        r_o_price   <= 32'd0;
                        r_o_qty     <= 32'd0;
                        r_o_time    <= 64'd0;
                        r_o_ident   <= r_ident;
                        r_o_ok      <= r_ok;
                        r_o_status  <= r_status;
                        r_o_bid     <= r_bid_found ? r_bid : 32'd0;
                        r_o_ask     <= r_ask_found ? r_ask : 32'd0;
                        r_o_last    <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_o_kind;
    assign o_aggressor_id = r_o_aggr;
    assign o_passive_id   = r_o_pas;
    assign o_trade_price  = r_o_price;
    assign o_trade_qty    = r_o_qty;
    assign o_trade_time   = r_o_time;
    assign o_order_ident  = r_o_ident;
    assign o_ok           = r_o_ok;
    assign o_order_status = r_o_status;
    assign o_best_bid     = r_o_bid;
    assign o_best_ask     = r_o_ask;
    assign o_last         = r_o_last;

endmodule

// ----- rtl/core/lobm_ram.sv -----
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/lobm_checker.sv -----
// Port-level checker for the limit order book matcher, bound to the top level.
// Depends on lobm_pkg.
module lobm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_result_kind,
    input logic [31:0] o_aggressor_id,
    input logic [31:0] o_trade_qty,
    input logic [31:0] o_order_ident,
    input logic        o_ok,
    input logic [1:0]  o_order_status,
    input logic        o_last
);

    import lobm_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_aggressor_id) &&
            $stable(o_trade_qty) && $stable(o_last))
        else $error("stalled item changed");

    a_trade_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == RES_TRADE |->
            !o_last && o_order_ident == 32'd0 && o_trade_qty != 32'd0 && !o_ok)
        else $error("malformed trade item");

    a_done_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == RES_DONE |-> o_last && o_trade_qty == 32'd0)
        else $error("malformed completion item");

    a_fail_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last && !o_ok |-> o_order_status == ST_NEW)
        else $error("failed request with non-new status");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_result_kind (o_result_kind),
    .o_aggressor_id(o_aggressor_id),
    .o_trade_qty   (o_trade_qty),
    .o_order_ident (o_order_ident),
    .o_ok          (o_ok),
    .o_order_status(o_order_status),
    .o_last        (o_last)
);

// ----- tb/lobm_checker.sv -----
// Checker of the limit order book matcher: watches both channels, keeps its own copy
// of the book, predicts trade and completion items and compares them. Depends on lobm_pkg.
`timescale 1ns / 100ps
module lobm_scoreboard (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_action,
    input  logic               i_side,
    input  logic [1:0]         i_order_kind,
    input  logic signed [31:0] i_limit_price,
    input  logic [31:0]        i_quantity,
    input  logic [63:0]        i_time_stamp,
    input  logic [31:0]        i_target_id,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_result_kind,
    input  logic [31:0]        i_aggressor_id,
    input  logic [31:0]        i_passive_id,
    input  logic signed [31:0] i_trade_price,
    input  logic [31:0]        i_trade_qty,
    input  logic [63:0]        i_trade_time,
    input  logic [31:0]        i_order_ident,
    input  logic               i_ok,
    input  logic [1:0]         i_order_status,
    input  logic signed [31:0] i_best_bid,
    input  logic signed [31:0] i_best_ask,
    input  logic               i_last,
    output int                 o_fail_count,
    output int                 o_pending
);

    import lobm_pkg::*;

    localparam int Q_DEPTH = 64;

    typedef struct packed {
        logic        kind;
        logic [31:0] aggr;
        logic [31:0] pas;
        logic [31:0] price;
        logic [31:0] qty;
        logic [63:0] tm;
        logic [31:0] ident;
        logic        ok;
        logic [1:0]  status;
        logic [31:0] bid;
        logic [31:0] ask;
        logic        last;
    } t_result;

    logic        bk_valid   [MAX_ORDERS];
    logic [31:0] bk_id      [MAX_ORDERS];
    logic        bk_side    [MAX_ORDERS];
    logic [31:0] bk_price   [MAX_ORDERS];
    logic [31:0] bk_size    [MAX_ORDERS];
    logic [31:0] bk_filled  [MAX_ORDERS];
    logic [31:0] bk_arrival [MAX_ORDERS];
    logic [31:0] next_order_id;
    logic [31:0] arrival_cnt;

    t_result due_q [Q_DEPTH];
    int      q_head = 0;
    int      q_tail = 0;
    int      fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = q_tail - q_head;

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t lobm_checker: %s got %0h expected %0h", $realtime, what, got, want);
        fails++;
    endtask

    task automatic stash_result(t_result r);
        due_q[q_tail % Q_DEPTH] = r;
        q_tail++;
    endtask

    function automatic logic [31:0] side_best(logic sd);
        logic        found;
        logic [31:0] best;
        found = 1'b0;
        best  = '0;
        for (int i = 0; i < MAX_ORDERS; i++) begin
            if (bk_valid[i] && bk_side[i] == sd) begin
                if (!found || (sd == SIDE_BUY ? $signed(bk_price[i]) > $signed(best)
                                              : $signed(bk_price[i]) < $signed(best))) begin
                    best  = bk_price[i];
                    found = 1'b1;
                end
            end
        end
        return best;
    endfunction

    function automatic int best_resting(logic aggr_side);
        int best;
        best = -1;
        for (int i = 0; i < MAX_ORDERS; i++) begin
            if (bk_valid[i] && bk_side[i] != aggr_side) begin
                if (best < 0) begin
                    best = i;
                end else if (aggr_side == SIDE_BUY ? $signed(bk_price[i]) < $signed(bk_price[best])
                                                   : $signed(bk_price[i]) > $signed(bk_price[best])) begin
                    best = i;
                end else if (bk_price[i] == bk_price[best] &&
                             (arrival_cnt - bk_arrival[i]) > (arrival_cnt - bk_arrival[best])) begin
                    best = i;
                end
            end
        end
        return best;
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < MAX_ORDERS; i++)
            if (!bk_valid[i]) return i;
        return -1;
    endfunction

    function automatic int find_order(logic [31:0] id);
        for (int i = 0; i < MAX_ORDERS; i++)
            if (bk_valid[i] && bk_id[i] == id) return i;
        return -1;
    endfunction

    task automatic book_request(logic [1:0] act, logic sd, logic [1:0] kind, logic [31:0] lim,
                                logic [31:0] qty, logic [63:0] tm, logic [31:0] target);
        t_result     r;
        int          p;
        int          s;
        logic [31:0] id;
        logic [31:0] rem;
        logic [31:0] avail;
        logic [31:0] f;
        logic [31:0] ident;
        logic        ok;
        logic [1:0]  st;
        logic        stop;
        ident = target;
        ok    = 1'b0;
        st    = ST_NEW;
        if (act == ACT_ADD) begin
            ident = '0;
            if (kind != KIND_BAD && free_slot() >= 0) begin
                id  = next_order_id;
                rem = qty;
                next_order_id = next_order_id + 32'd1;
                if (next_order_id == 32'd0) next_order_id = 32'd1;
                stop = 1'b0;
                while (rem != 0 && !stop) begin
                    p = best_resting(sd);
                    if (p < 0) begin
                        stop = 1'b1;
                    end else if (kind != KIND_MARKET &&
                                 (sd == SIDE_BUY ? $signed(lim) < $signed(bk_price[p])
                                                 : $signed(lim) > $signed(bk_price[p]))) begin
                        stop = 1'b1;
                    end else begin
                        avail = (bk_size[p] > bk_filled[p]) ? bk_size[p] - bk_filled[p] : '0;
                        f = (rem < avail) ? rem : avail;
                        if (f != 0) begin
                            r = '0;
                            r.kind  = RES_TRADE;
                            r.aggr  = id;
                            r.pas   = bk_id[p];
                            r.price = bk_price[p];
                            r.qty   = f;
                            r.tm    = tm;
                            stash_result(r);
                        end
                        rem = rem - f;
                        bk_filled[p] = bk_filled[p] + f;
                        if (bk_filled[p] >= bk_size[p]) bk_valid[p] = 1'b0;
                    end
                end
                if (rem == 0) begin
                    st = ST_FILLED;
                end else if (kind == KIND_LIMIT) begin
                    s = free_slot();
                    if (s >= 0) begin
                        bk_valid[s]   = 1'b1;
                        bk_id[s]      = id;
                        bk_side[s]    = sd;
                        bk_price[s]   = lim;
                        bk_size[s]    = qty;
                        bk_filled[s]  = qty - rem;
                        bk_arrival[s] = arrival_cnt;
                        arrival_cnt   = arrival_cnt + 32'd1;
                    end
                    st = (rem != qty) ? ST_PARTIAL : ST_NEW;
                end else begin
                    st = ST_CANCELLED;
                end
                ident = id;
                ok    = 1'b1;
            end
        end else if (act == ACT_CANCEL) begin
            s = find_order(target);
            if (s >= 0) begin
                bk_valid[s] = 1'b0;
                ok = 1'b1;
                st = ST_CANCELLED;
            end
        end else if (act == ACT_REDUCE) begin
            s = find_order(target);
            if (s >= 0 && qty < bk_size[s] && qty > bk_filled[s]) begin
                bk_size[s] = qty;
                ok = 1'b1;
                st = (bk_filled[s] != 0) ? ST_PARTIAL : ST_NEW;
            end
        end
        r = '0;
        r.kind   = RES_DONE;
        r.ident  = ident;
        r.ok     = ok;
        r.status = st;
        r.bid    = side_best(SIDE_BUY);
        r.ask    = side_best(SIDE_SELL);
        r.last   = 1'b1;
        stash_result(r);
    endtask

    task automatic check_result();
        t_result w;
        if (q_tail == q_head) begin
            flag_mismatch("unexpected item, kind", i_result_kind, 0);
            return;
        end
        w = due_q[q_head % Q_DEPTH];
        q_head++;
        if (i_result_kind  !== w.kind)   flag_mismatch("result_kind", i_result_kind, w.kind);
        if (i_aggressor_id !== w.aggr)   flag_mismatch("aggressor_id", i_aggressor_id, w.aggr);
        if (i_passive_id   !== w.pas)    flag_mismatch("passive_id", i_passive_id, w.pas);
        if (i_trade_price  !== w.price)  flag_mismatch("trade_price", i_trade_price, w.price);
        if (i_trade_qty    !== w.qty)    flag_mismatch("trade_qty", i_trade_qty, w.qty);
        if (i_trade_time   !== w.tm)     flag_mismatch("trade_time", i_trade_time, w.tm);
        if (i_order_ident  !== w.ident)  flag_mismatch("order_ident", i_order_ident, w.ident);
        if (i_ok           !== w.ok)     flag_mismatch("ok", i_ok, w.ok);
        if (i_order_status !== w.status) flag_mismatch("order_status", i_order_status, w.status);
        if (i_best_bid     !== w.bid)    flag_mismatch("best_bid", i_best_bid, w.bid);
        if (i_best_ask     !== w.ask)    flag_mismatch("best_ask", i_best_ask, w.ask);
        if (i_last         !== w.last)   flag_mismatch("last", i_last, w.last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ORDERS; i++) begin
                bk_valid[i]   = 1'b0;
                bk_id[i]      = '0;
                bk_side[i]    = 1'b0;
                bk_price[i]   = '0;
                bk_size[i]    = '0;
                bk_filled[i]  = '0;
                bk_arrival[i] = '0;
            end
            next_order_id = 32'd1;
            arrival_cnt   = 32'd0;
            q_head        = 0;
            q_tail        = 0;
        end else begin
            if (i_out_valid && !i_out_stall) check_result();
            if (i_in_valid && !i_in_stall)
                book_request(i_action, i_side, i_order_kind, i_limit_price, i_quantity,
                             i_time_stamp, i_target_id);
        end
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top of the limit order book matcher: clock, reset, request stimulus,
// output stall, watchdog and verdict. Depends on lobm_pkg, lobm_scoreboard and the block.
`timescale 1ns / 100ps
module tb;
    import lobm_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         action = '0;
    logic               side = 1'b0;
    logic [1:0]         order_kind = '0;
    logic signed [31:0] limit_price = '0;
    logic [31:0]        quantity = '0;
    logic [63:0]        time_stamp = '0;
    logic [31:0]        target_id = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               result_kind;
    logic [31:0]        aggressor_id;
    logic [31:0]        passive_id;
    logic signed [31:0] trade_price;
    logic [31:0]        trade_qty;
    logic [63:0]        trade_time;
    logic [31:0]        order_ident;
    logic               ok;
    logic [1:0]         order_status;
    logic signed [31:0] best_bid;
    logic signed [31:0] best_ask;
    logic               last;
    int                 fail_count;
    int                 pending;

    int send_idle_pct = 18;
    int recv_idle_pct = 86;
    int adds_sent = 0;
    int quiet_cycles = 0;

    limit_order_book_matcher dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_action(action), .i_side(side), .i_order_kind(order_kind),
        .i_limit_price(limit_price), .i_quantity(quantity), .i_time_stamp(time_stamp),
        .i_target_id(target_id),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_result_kind(result_kind), .o_aggressor_id(aggressor_id),
        .o_passive_id(passive_id), .o_trade_price(trade_price), .o_trade_qty(trade_qty),
        .o_trade_time(trade_time), .o_order_ident(order_ident), .o_ok(ok),
        .o_order_status(order_status), .o_best_bid(best_bid), .o_best_ask(best_ask),
        .o_last(last)
    );

    lobm_scoreboard u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_action(action), .i_side(side), .i_order_kind(order_kind),
        .i_limit_price(limit_price), .i_quantity(quantity), .i_time_stamp(time_stamp),
        .i_target_id(target_id),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_result_kind(result_kind), .i_aggressor_id(aggressor_id),
        .i_passive_id(passive_id), .i_trade_price(trade_price), .i_trade_qty(trade_qty),
        .i_trade_time(trade_time), .i_order_ident(order_ident), .i_ok(ok),
        .i_order_status(order_status), .i_best_bid(best_bid), .i_best_ask(best_ask),
        .i_last(last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 == IDLE_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    task automatic send_request(logic [1:0] act, logic sd, logic [1:0] kind, logic [31:0] lim,
                                logic [31:0] qty, logic [63:0] ts, logic [31:0] target);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        side        <= sd;
        order_kind  <= kind;
        limit_price <= lim;
        quantity    <= qty;
        time_stamp  <= ts;
        target_id   <= target;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (act == ACT_ADD && kind != KIND_BAD) adds_sent++;
    endtask

    function automatic logic [63:0] rand_ts();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] pick_target();
        int lo;
        if ($urandom_range(19) == 0) return $urandom;
        lo = (adds_sent > 35) ? adds_sent - 35 : 0;
        return $urandom_range(adds_sent + 2, lo);
    endfunction

    function automatic logic [31:0] pick_qty();
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 8) return $urandom;
        return $urandom_range(20, 1);
    endfunction

    task automatic mixed_request();
        int          r;
        logic        sd;
        logic [1:0]  kind;
        logic [31:0] lim;
        r    = $urandom_range(99);
        sd   = 1'($urandom_range(1));
        kind = ($urandom_range(99) < 60) ? KIND_LIMIT :
               ($urandom_range(99) < 40) ? KIND_MARKET : KIND_IOC;
        lim  = $urandom_range(105, 95);
        if ($urandom_range(19) == 0) lim = $urandom;
        if (r < 60)
            send_request(ACT_ADD, sd, kind, lim, pick_qty(), rand_ts(), $urandom);
        else if (r < 75)
            send_request(ACT_CANCEL, 1'($urandom), 2'($urandom), $urandom, $urandom, rand_ts(),
                         pick_target());
        else if (r < 90)
            send_request(ACT_REDUCE, 1'($urandom), 2'($urandom), $urandom, $urandom_range(25),
                         rand_ts(), pick_target());
        else if (r < 95)
            send_request(ACT_ADD, sd, KIND_BAD, lim, pick_qty(), rand_ts(), $urandom);
        else
            send_request(ACT_UNUSED, 1'($urandom), 2'($urandom), $urandom, $urandom, rand_ts(),
                         $urandom);
    endtask

    task automatic fill_book();
        for (int k = 0; k < MAX_ORDERS + 2; k++) begin
            if ($urandom_range(1))
                send_request(ACT_ADD, SIDE_BUY, KIND_LIMIT, $urandom_range(99, 90),
                             $urandom_range(30, 1), rand_ts(), '0);
            else
                send_request(ACT_ADD, SIDE_SELL, KIND_LIMIT, $urandom_range(110, 101),
                             $urandom_range(30, 1), rand_ts(), '0);
        end
        send_request(ACT_ADD, 1'($urandom), KIND_MARKET, $urandom, 32'hFFFF_FFFF, rand_ts(), '0);
    endtask

    initial begin
        int sent;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(ACT_ADD, SIDE_BUY, KIND_LIMIT, 32'sd100, 32'd10, '1, '0);
        send_request(ACT_ADD, SIDE_SELL, KIND_LIMIT, 32'sd105, 32'd5, rand_ts(), '0);
        send_request(ACT_ADD, SIDE_SELL, KIND_LIMIT, 32'sd105, 32'd7, rand_ts(), '0);
        send_request(ACT_ADD, SIDE_BUY, KIND_MARKET, 32'sd0, 32'd8, rand_ts(), '0);
        send_request(ACT_ADD, SIDE_BUY, KIND_IOC, 32'sd104, 32'd3, rand_ts(), '0);
        send_request(ACT_ADD, SIDE_SELL, KIND_LIMIT, 32'sd101, 32'd0, rand_ts(), '0);
        send_request(ACT_ADD, SIDE_BUY, KIND_BAD, 32'sd100, 32'd4, rand_ts(), '1);
        send_request(ACT_REDUCE, SIDE_BUY, KIND_LIMIT, '0, 32'd2, '0, 32'd3);
        send_request(ACT_REDUCE, SIDE_BUY, KIND_LIMIT, '0, 32'd5, '0, 32'd3);
        send_request(ACT_REDUCE, SIDE_BUY, KIND_LIMIT, '0, 32'd10, '0, 32'd1);
        send_request(ACT_CANCEL, SIDE_BUY, KIND_LIMIT, '0, '0, '0, 32'd1);
        send_request(ACT_CANCEL, SIDE_BUY, KIND_LIMIT, '0, '0, '0, 32'd1);
        send_request(ACT_UNUSED, SIDE_SELL, KIND_BAD, '1, '1, '1, 32'hFFFF_FFFF);
        send_request(ACT_ADD, SIDE_BUY, KIND_LIMIT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, rand_ts(), '0);
        send_request(ACT_ADD, SIDE_SELL, KIND_LIMIT, 32'h8000_0000, 32'd1, rand_ts(), '0);
        send_request(ACT_ADD, SIDE_SELL, KIND_MARKET, '1, 32'hFFFF_FFFF, rand_ts(), '0);
        send_request(ACT_ADD, SIDE_SELL, KIND_LIMIT, -32'sd5, 32'd4, rand_ts(), '0);
        send_request(ACT_ADD, SIDE_BUY, KIND_IOC, -32'sd5, 32'd4, '0, '0);
        send_request(ACT_CANCEL, SIDE_BUY, KIND_LIMIT, '0, '0, '0, '0);
        send_request(ACT_REDUCE, SIDE_SELL, KIND_MARKET, '0, 32'd1, '0, 32'hFFFF_FFFF);

        sent = 0;
        while (sent < 310) begin
            if (sent >= 200) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (sent >= 95) begin
                send_idle_pct = 86;
                recv_idle_pct = 18;
            end
            if ($urandom_range(5) == 0) begin
                fill_book();
                sent += MAX_ORDERS + 3;
            end else begin
                repeat (20) mixed_request();
                sent += 20;
            end
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (100) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
